[sv/qss_pkg.sv]
package qss_pkg;

    localparam int DATA_W = 32;

    // operations the controller asks of the datapath, one per cycle
    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_PUSH_INIT,
        CMD_POP,
        CMD_RANGE,
        CMD_PIVOT,
        CMD_R_READ,
        CMD_R_DEC,
        CMD_R_SWAP,
        CMD_L_READ,
        CMD_L_INC,
        CMD_L_SWAP,
        CMD_PLACE,
        CMD_PUSH_LO,
        CMD_PUSH_HI,
        CMD_OUT_READ,
        CMD_OUT_LOAD,
        CMD_CLEAR
    } qss_cmd_t;

    typedef struct packed {
        logic count_lt2;
        logic stack_empty;
        logic piv_eq_right;
        logic piv_eq_left;
        logic r_keep;       // pivot <= element read on the right side
        logic l_keep;       // element read on the left side <= pivot
        logic push_lo_ok;
        logic push_hi_ok;
        logic out_last;
    } qss_status_t;

endpackage

[sv/qss_ctrl.sv]
module qss_ctrl
    import qss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tlast,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  qss_status_t status,
    output qss_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_LOAD,
        S_START,
        S_POP_RD,
        S_POP_DATA,
        S_PIV_DATA,
        S_R_CHECK,
        S_R_CMP,
        S_L_CHECK,
        S_L_CMP,
        S_FINISH,
        S_PUSH_LO,
        S_PUSH_HI,
        S_OUT_RD,
        S_OUT_SHOW,
        S_OUT_WAIT
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    assign s_tready = (state_reg == S_LOAD);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd           = CMD_NONE;
        case (state_reg)
            S_LOAD: begin
                if (s_tvalid) begin
                    cmd = CMD_LOAD;
                    if (s_tlast) begin
                        state_next = S_START;
                    end
                end
            end
            S_START: begin
                if (status.count_lt2) begin
                    state_next = S_OUT_RD;
                end else begin
                    cmd        = CMD_PUSH_INIT;
                    state_next = S_POP_RD;
                end
            end
            S_POP_RD: begin
                if (status.stack_empty) begin
                    state_next = S_OUT_RD;
                end else begin
                    cmd        = CMD_POP;
                    state_next = S_POP_DATA;
                end
            end
            S_POP_DATA: begin
                cmd        = CMD_RANGE;
                state_next = S_PIV_DATA;
            end
            S_PIV_DATA: begin
                cmd        = CMD_PIVOT;
                state_next = S_R_CHECK;
            end
            S_R_CHECK: begin
                if (status.piv_eq_right) begin
                    state_next = S_FINISH;
                end else begin
                    cmd        = CMD_R_READ;
                    state_next = S_R_CMP;
                end
            end
            S_R_CMP: begin
                if (status.r_keep) begin
                    cmd        = CMD_R_DEC;
                    state_next = S_R_CHECK;
                end else begin
                    cmd        = CMD_R_SWAP;
                    state_next = S_L_CHECK;
                end
            end
            S_L_CHECK: begin
                if (status.piv_eq_left) begin
                    state_next = S_FINISH;
                end else begin
                    cmd        = CMD_L_READ;
                    state_next = S_L_CMP;
                end
            end
            S_L_CMP: begin
                if (status.l_keep) begin
                    cmd        = CMD_L_INC;
                    state_next = S_L_CHECK;
                end else begin
                    cmd        = CMD_L_SWAP;
                    state_next = S_R_CHECK;
                end
            end
            S_FINISH: begin
                cmd        = CMD_PLACE;
                state_next = S_PUSH_LO;
            end
            S_PUSH_LO: begin
                if (status.push_lo_ok) begin
                    cmd = CMD_PUSH_LO;
                end
                state_next = S_PUSH_HI;
            end
            S_PUSH_HI: begin
                if (status.push_hi_ok) begin
                    cmd = CMD_PUSH_HI;
                end
                state_next = S_POP_RD;
            end
            S_OUT_RD: begin
                cmd        = CMD_OUT_READ;
                state_next = S_OUT_SHOW;
            end
            S_OUT_SHOW: begin
                cmd           = CMD_OUT_LOAD;
                m_tvalid_next = 1'b1;
                state_next    = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (m_tready) begin
                    m_tvalid_next = 1'b0;
                    if (status.out_last) begin
                        cmd        = CMD_CLEAR;
                        state_next = S_LOAD;
                    end else begin
                        state_next = S_OUT_RD;
                    end
                end
            end
            default: begin
                state_next    = S_LOAD;
                m_tvalid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_LOAD;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

[sv/qss_datapath.sv]
module qss_datapath
    import qss_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  qss_cmd_t                 cmd,
    input  logic signed [DATA_W-1:0] s_data,
    output qss_status_t              status,
    output logic signed [DATA_W-1:0] m_data,
    output logic                     m_last,
    output logic                     m_dropped
);

    localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ELEMENTS);

    logic signed [DATA_W-1:0] store_mem [MAX_ELEMENTS];
    logic [2*IDX_W-1:0]       stack_mem [MAX_ELEMENTS];

    logic signed [DATA_W-1:0] st_rdata_reg;
    logic [2*IDX_W-1:0]       stk_rdata_reg;

    logic [CNT_W-1:0]         count_reg;
    logic                     ovf_reg;
    logic [CNT_W-1:0]         top_reg;
    logic [IDX_W-1:0]         out_idx_reg;
    logic [IDX_W-1:0]         lo_reg, hi_reg, left_reg, right_reg, piv_reg;
    logic signed [DATA_W-1:0] pivot_reg;
    logic signed [DATA_W-1:0] m_data_reg;
    logic                     m_last_reg;

    logic                     st_we;
    logic [IDX_W-1:0]         st_waddr, st_raddr;
    logic signed [DATA_W-1:0] st_wdata;
    logic                     stk_we;
    logic [IDX_W-1:0]         stk_raddr;
    logic [2*IDX_W-1:0]       stk_wdata;

    logic [CNT_W-1:0]         count_m1;
    logic [CNT_W-1:0]         top_m1;
    logic                     stack_full;
    logic [IDX_W-1:0]         stk_lo, stk_hi;

    assign count_m1   = count_reg - CNT_W'(1);
    assign top_m1     = top_reg - CNT_W'(1);
    assign stack_full = (top_reg == CNT_MAX);
    assign stk_lo     = stk_rdata_reg[2*IDX_W-1:IDX_W];
    assign stk_hi     = stk_rdata_reg[IDX_W-1:0];

    always_comb begin
        st_we     = 1'b0;
        st_waddr  = piv_reg;
        st_wdata  = st_rdata_reg;
        st_raddr  = right_reg;
        stk_we    = 1'b0;
        stk_raddr = top_m1[IDX_W-1:0];
        stk_wdata = {lo_reg, piv_reg - IDX_W'(1)};
        case (cmd)
            CMD_LOAD: begin
                st_we    = (count_reg < CNT_MAX);
                st_waddr = count_reg[IDX_W-1:0];
                st_wdata = s_data;
            end
            CMD_PUSH_INIT: begin
                stk_we    = 1'b1;
                stk_wdata = {IDX_W'(0), count_m1[IDX_W-1:0]};
            end
            CMD_RANGE:    st_raddr = stk_lo;
            CMD_R_READ:   st_raddr = right_reg;
            CMD_L_READ:   st_raddr = left_reg;
            CMD_R_SWAP:   st_we = 1'b1;
            CMD_L_SWAP:   st_we = 1'b1;
            CMD_PLACE: begin
                st_we    = 1'b1;
                st_wdata = pivot_reg;
            end
            CMD_PUSH_LO: begin
                stk_we    = !stack_full;
                stk_wdata = {lo_reg, piv_reg - IDX_W'(1)};
            end
            CMD_PUSH_HI: begin
                stk_we    = !stack_full;
                stk_wdata = {piv_reg + IDX_W'(1), hi_reg};
            end
            CMD_OUT_READ: st_raddr = out_idx_reg;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (st_we) begin
            store_mem[st_waddr] <= st_wdata;
        end
        st_rdata_reg <= store_mem[st_raddr];
        if (stk_we) begin
            stack_mem[top_reg[IDX_W-1:0]] <= stk_wdata;
        end
        stk_rdata_reg <= stack_mem[stk_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            top_reg     <= '0;
            out_idx_reg <= '0;
        end else begin
            case (cmd)
                CMD_LOAD: begin
                    if (count_reg < CNT_MAX) begin
                        count_reg <= count_reg + CNT_W'(1);
                    end else begin
                        ovf_reg <= 1'b1;
                    end
                end
                CMD_PUSH_INIT: top_reg <= CNT_W'(1);
                CMD_POP:       top_reg <= top_m1;
                CMD_RANGE: begin
                    lo_reg    <= stk_lo;
                    hi_reg    <= stk_hi;
                    left_reg  <= stk_lo;
                    right_reg <= stk_hi;
                    piv_reg   <= stk_lo;
                end
                CMD_PIVOT:  pivot_reg <= st_rdata_reg;
                CMD_R_DEC:  right_reg <= right_reg - IDX_W'(1);
                CMD_R_SWAP: piv_reg   <= right_reg;
                CMD_L_INC:  left_reg  <= left_reg + IDX_W'(1);
                CMD_L_SWAP: piv_reg   <= left_reg;
                CMD_PUSH_LO, CMD_PUSH_HI: begin
                    if (!stack_full) begin
                        top_reg <= top_reg + CNT_W'(1);
                    end
                end
                CMD_OUT_LOAD: begin
                    m_data_reg  <= st_rdata_reg;
                    m_last_reg  <= ({1'b0, out_idx_reg} + (IDX_W+1)'(1))
                                   == (IDX_W+1)'(count_reg);
                    out_idx_reg <= out_idx_reg + IDX_W'(1);
                end
                CMD_CLEAR: begin
                    count_reg   <= '0;
                    ovf_reg     <= 1'b0;
                    out_idx_reg <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign status.count_lt2    = (count_reg < CNT_W'(2));
    assign status.stack_empty  = (top_reg == '0);
    assign status.piv_eq_right = (piv_reg == right_reg);
    assign status.piv_eq_left  = (piv_reg == left_reg);
    assign status.r_keep       = (pivot_reg <= st_rdata_reg);
    assign status.l_keep       = (st_rdata_reg <= pivot_reg);
    assign status.push_lo_ok   = ({1'b0, piv_reg} > ({1'b0, lo_reg} + (IDX_W+1)'(1)));
    assign status.push_hi_ok   = (({1'b0, piv_reg} + (IDX_W+1)'(1)) < {1'b0, hi_reg});
    assign status.out_last     = m_last_reg;

    assign m_data    = m_data_reg;
    assign m_last    = m_last_reg;
    assign m_dropped = ovf_reg;

endmodule

[sv/quicksort_sort_engine.sv]
// Block sorter for signed 32-bit values.
// Input channel s_*: one element per transaction, s_tlast marks the final
// element of a block. Elements beyond MAX_ELEMENTS are discarded and the
// block's results then carry m_tuser = 1.
// Output channel m_*: the held elements in ascending order, duplicates kept,
// m_tlast on the final one.
// Loading accepts one element per cycle. After the last element the block is
// sorted in place by quicksort with a range stack: each pivot compare is one
// store read with registered data followed by the compare, and each range adds
// the steps of pop, pivot fetch, closing check, placement and pushes.
// Random input averages about 1.4*N*log2(N) compares; already ordered input
// is the worst case. Results then leave one at a time: each is read from the
// store, loaded into the output register and held there until taken; a
// stalled receiver simply holds the current result in the output register.
// s_tready is low from the last input element until the final result has
// been taken. Reset clears the element count, the drop flag and the stack;
// store contents are not cleared and need no clearing pass.
module quicksort_sort_engine
    import qss_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] data_value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] sorted_value
    output logic        m_tlast,
    output logic        m_tuser    // [0] dropped_flag
);

    qss_cmd_t                 cmd;
    qss_status_t              status;
    logic signed [DATA_W-1:0] m_data;

    qss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    qss_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_data    ($signed(s_tdata)),
        .status    (status),
        .m_data    (m_data),
        .m_last    (m_tlast),
        .m_dropped (m_tuser)
    );

    assign m_tdata = $unsigned(m_data);

endmodule

[tb/sort_checker.sv]
`timescale 1ns / 100ps

module sort_checker
    import qss_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,
    input  logic              s_tlast,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [DATA_W-1:0] m_tdata,
    input  logic              m_tlast,
    input  logic              m_tuser,
    output int                fail_count,
    output int                sorted_pending,
    output int                sorted_checked
);

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     dropped;
    } sorted_item_t;

    logic signed [DATA_W-1:0] block_store [CAPACITY];
    int                       block_len;
    logic                     block_dropped;
    sorted_item_t             sorted_queue [$];

    // ascending order of a multiset is unique, so any stable sort gives the
    // same stream as the engine's partitioning
    function automatic void queue_sorted_block();
        logic signed [DATA_W-1:0] work [CAPACITY];
        logic signed [DATA_W-1:0] key;
        sorted_item_t             item;
        int                       j;
        for (int i = 0; i < block_len; i++) work[i] = block_store[i];
        for (int i = 1; i < block_len; i++) begin
            key = work[i];
            j = i - 1;
            while (j >= 0 && work[j] > key) begin
                work[j + 1] = work[j];
                j--;
            end
            work[j + 1] = key;
        end
        for (int i = 0; i < block_len; i++) begin
            item.value   = work[i];
            item.last    = (i == block_len - 1);
            item.dropped = block_dropped;
            sorted_queue.push_back(item);
        end
    endfunction

    always @(posedge aclk) begin : monitor
        sorted_item_t want;
        if (!aresetn) begin
            block_len = 0;
            block_dropped = 1'b0;
            sorted_queue.delete();
            fail_count = 0;
            sorted_checked = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (sorted_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result value %0d (%h) last %b dropped %b",
                                 $time, $signed(m_tdata), m_tdata, m_tlast, m_tuser);
                end else begin
                    want = sorted_queue.pop_front();
                    if (m_tdata !== want.value || m_tlast !== want.last
                            || m_tuser !== want.dropped) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: result mismatch: expected value %0d (%h) last %b ",
                                     $time, want.value, want.value, want.last,
                                     "dropped %b, got value %0d (%h) last %b dropped %b",
                                     want.dropped, $signed(m_tdata), m_tdata, m_tlast,
                                     m_tuser);
                    end
                    sorted_checked++;
                end
            end
            if (s_tvalid && s_tready) begin
                if (block_len < CAPACITY) begin
                    block_store[block_len] = s_tdata;
                    block_len++;
                end else begin
                    block_dropped = 1'b1;
                end
                if (s_tlast) begin
                    queue_sorted_block();
                    block_len = 0;
                    block_dropped = 1'b0;
                end
            end
        end
        sorted_pending = sorted_queue.size();
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import qss_pkg::*;

    localparam int CAPACITY    = 64;
    localparam int IDLE_LIMIT  = 100000;
    localparam int TAIL_CYCLES = 40;
    localparam int ITEM_TARGET = 300;
    localparam int N_DIRECTED  = 25;

    typedef enum {
        FILL_RANDOM,
        FILL_NARROW,
        FILL_EXTREME,
        FILL_RISING,
        FILL_FALLING
    } fill_kind_t;

    // {last, value}: single min/max, sign boundary pairs, all-equal,
    // mixed extremes with repeats, sorted and reverse-sorted runs
    localparam logic [DATA_W:0] DIRECTED [N_DIRECTED] = '{
        {1'b1, 32'h8000_0000},
        {1'b1, 32'h7FFF_FFFF},
        {1'b0, 32'h7FFF_FFFF}, {1'b1, 32'h8000_0000},
        {1'b0, 32'h0000_0000}, {1'b1, 32'hFFFF_FFFF},
        {1'b0, 32'd5}, {1'b0, 32'd5}, {1'b0, 32'd5}, {1'b1, 32'd5},
        {1'b0, 32'd3}, {1'b0, 32'h8000_0000}, {1'b0, 32'h7FFF_FFFF},
        {1'b0, 32'hFFFF_FFFF}, {1'b0, 32'd0}, {1'b0, 32'd3},
        {1'b0, 32'h8000_0000}, {1'b0, 32'd1}, {1'b1, 32'hFFFF_FFFE},
        {1'b0, 32'd1}, {1'b0, 32'd2}, {1'b1, 32'd3},
        {1'b0, 32'd3}, {1'b0, 32'd2}, {1'b1, 32'd1}
    };

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic [DATA_W-1:0] s_tdata  = '0;
    logic              s_tlast  = 1'b0;
    logic              m_tready = 1'b0;
    logic              s_tready;
    logic              m_tvalid;
    logic [DATA_W-1:0] m_tdata;
    logic              m_tlast;
    logic              m_tuser;

    int fail_count;
    int sorted_pending;
    int sorted_checked;
    int items_sent      = 0;
    int blocks_sent     = 0;
    int overflow_blocks = 0;
    int idle_cycles     = 0;
    int ready_hold      = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    quicksort_sort_engine #(
        .MAX_ELEMENTS(CAPACITY)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    sort_checker #(
        .CAPACITY(CAPACITY)
    ) i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .sorted_pending(sorted_pending),
        .sorted_checked(sorted_checked)
    );

    // receiver: runs of ready, short stalls, now and then a long one
    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold--;
        end else if ($urandom_range(0, 9) < 6) begin
            m_tready <= 1'b1;
            ready_hold = $urandom_range(0, 30);
        end else begin
            m_tready <= 1'b0;
            ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                      : $urandom_range(0, 2);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, sorted_pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int sender_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // called and returns at a falling edge
    task automatic send_item(input logic [DATA_W-1:0] value, input logic last);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
        if (last) blocks_sent++;
    endtask

    task automatic send_block(input int len, input fill_kind_t kind);
        logic [DATA_W-1:0] ramp;
        logic [DATA_W-1:0] value;
        ramp = (kind == FILL_RISING) ? 32'h8000_0000 + $urandom_range(0, 1000)
                                     : 32'h7FFF_FFFF - $urandom_range(0, 1000);
        for (int k = 0; k < len; k++) begin
            case (kind)
                FILL_RANDOM: value = $urandom;
                FILL_NARROW: value = $urandom_range(0, 6) - 3;
                FILL_EXTREME: begin
                    case ($urandom_range(0, 4))
                        0:       value = 32'h8000_0000;
                        1:       value = 32'h7FFF_FFFF;
                        2:       value = 32'hFFFF_FFFF;
                        3:       value = 32'h0000_0000;
                        default: value = 32'h0000_0001;
                    endcase
                end
                FILL_RISING: begin
                    value = ramp;
                    ramp = ramp + $urandom_range(0, 3);
                end
                default: begin
                    value = ramp;
                    ramp = ramp - $urandom_range(0, 3);
                end
            endcase
            send_item(value, k == len - 1);
        end
        if (len > CAPACITY) overflow_blocks++;
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (sorted_pending != 0);
    endtask

    initial begin : stimulus
        int         len;
        fill_kind_t kind;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_item(DIRECTED[i][DATA_W-1:0], DIRECTED[i][DATA_W]);
        hold_until_drained();

        // exactly full, last element dropped, several dropped
        send_block(CAPACITY, FILL_RISING);
        send_block(CAPACITY + 1, FILL_FALLING);
        send_block(CAPACITY + 6, FILL_RANDOM);

        while (items_sent < N_DIRECTED + ITEM_TARGET) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            kind = fill_kind_t'($urandom_range(0, 4));
            send_block(len, kind);
            if ($urandom_range(0, 3) == 0) hold_until_drained();
        end

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d elements in %0d blocks, %0d of them past store capacity",
                 items_sent, blocks_sent, overflow_blocks);
        $display("Checked %0d sorted results, %0d mismatches, %0d still outstanding",
                 sorted_checked, fail_count, sorted_pending);
        if (fail_count == 0 && sorted_pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
sv/qss_pkg.sv
sv/qss_ctrl.sv
sv/qss_datapath.sv
sv/quicksort_sort_engine.sv
tb/sort_checker.sv
tb/testbench.sv
